FILE: rtl/core/gpc_pkg.sv
package gpc_pkg;

	// exp table depth, a power of two
	localparam int unsigned EXP_TABLE_DEPTH = 256;
	localparam int unsigned EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
	localparam int unsigned EXP_W           = 17;    // entries reach 1.0 in Q16

	localparam int unsigned POS_W    = 16;
	localparam int unsigned WEIGHT_W = 16;
	localparam int unsigned SUM_W    = 32;
	localparam int unsigned CFG_W    = 32;
	localparam int unsigned REG_ADDR_W = 4;

	localparam logic [16:0] LOG2E_Q16    = 17'd94548;
	localparam logic [15:0] INV_NORM_Q16 = 16'd46481;

	localparam logic [WEIGHT_W-1:0] WEIGHT_X_RST = 16'd5851;
	localparam logic [WEIGHT_W-1:0] WEIGHT_Y_RST = 16'd38280;
	localparam logic [WEIGHT_W-1:0] WEIGHT_Z_RST = 16'd38280;

	localparam logic [1:0] REG_WEIGHT_X = 2'd0;
	localparam logic [1:0] REG_WEIGHT_Y = 2'd1;
	localparam logic [1:0] REG_WEIGHT_Z = 2'd2;

	typedef struct packed {
		logic [WEIGHT_W-1:0] x;
		logic [WEIGHT_W-1:0] y;
		logic [WEIGHT_W-1:0] z;
	} weights_t;

	typedef logic [EXP_W-1:0] exp_table_t [EXP_TABLE_DEPTH];

	localparam longint unsigned LN2_Q30 = 64'd744261118;

	// unsigned quotient by restoring shift and subtract, table construction only
	function automatic longint unsigned udiv64(input longint unsigned num,
			input longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = 64'd0;
		rem = 64'd0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			quo = {quo[62:0], 1'b0};
			if (rem >= den) begin
				rem    = rem - den;
				quo[0] = 1'b1;
			end
		end
		return quo;
	endfunction

	// 2^(-k/depth) in Q16, alternating Taylor series of exp(-k*ln2/depth) in Q30
	function automatic exp_table_t build_exp_table();
		exp_table_t      tbl;
		longint unsigned y;
		longint unsigned term;
		longint unsigned pos;
		longint unsigned neg;
		for (int unsigned k = 0; k < EXP_TABLE_DEPTH; k++) begin
			y    = (longint'(k) * LN2_Q30) >> EXP_IDX_W;
			term = 64'd1 << 30;
			pos  = term;
			neg  = 64'd0;
			for (int unsigned i = 1; i <= 24; i++) begin
				term = udiv64((term * y) >> 30, 64'(i));
				if (i[0]) begin
					neg = neg + term;
				end else begin
					pos = pos + term;
				end
			end
			tbl[k] = EXP_W'(((pos - neg) + 64'd8192) >> 14);
		end
		return tbl;
	endfunction

	localparam exp_table_t EXP2_TABLE = build_exp_table();

endpackage

FILE: rtl/core/gpc_if.sv
interface gpc_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [gpc_pkg::POS_W-1:0]   query_x;
	logic signed [gpc_pkg::POS_W-1:0]   query_y;
	logic signed [gpc_pkg::POS_W-1:0]   query_z;
	logic signed [gpc_pkg::POS_W-1:0]   puff_x;
	logic signed [gpc_pkg::POS_W-1:0]   puff_y;
	logic signed [gpc_pkg::POS_W-1:0]   puff_z;
	logic                               puff_present;
	logic                               first_puff;
	logic                               last_puff;

	modport source (
		output valid, query_x, query_y, query_z, puff_x, puff_y, puff_z,
		       puff_present, first_puff, last_puff,
		input  ready
	);
	modport sink (
		input  valid, query_x, query_y, query_z, puff_x, puff_y, puff_z,
		       puff_present, first_puff, last_puff,
		output ready
	);
endinterface

interface gpc_out_if;
	logic                        valid;
	logic                        ready;
	logic [gpc_pkg::SUM_W-1:0]   concentration;
	logic                        saturated;

	modport source (output valid, concentration, saturated, input ready);
	modport sink (input valid, concentration, saturated, output ready);
endinterface

FILE: rtl/core/gpc_apb_regs.sv
module gpc_apb_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [gpc_pkg::REG_ADDR_W-1:0]   paddr,
	input  logic [gpc_pkg::CFG_W-1:0]        pwdata,
	output logic [gpc_pkg::CFG_W-1:0]        prdata,
	output logic                             pready,
	output gpc_pkg::weights_t                weights
);

	gpc_pkg::weights_t weights_q;
	logic              wr_en;
	logic [1:0]        reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[gpc_pkg::REG_ADDR_W-1:2];
	assign weights = weights_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weights_q.x <= gpc_pkg::WEIGHT_X_RST;
			weights_q.y <= gpc_pkg::WEIGHT_Y_RST;
			weights_q.z <= gpc_pkg::WEIGHT_Z_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				gpc_pkg::REG_WEIGHT_X: weights_q.x <= pwdata[gpc_pkg::WEIGHT_W-1:0];
				gpc_pkg::REG_WEIGHT_Y: weights_q.y <= pwdata[gpc_pkg::WEIGHT_W-1:0];
				gpc_pkg::REG_WEIGHT_Z: weights_q.z <= pwdata[gpc_pkg::WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			gpc_pkg::REG_WEIGHT_X: prdata = gpc_pkg::CFG_W'(weights_q.x);
			gpc_pkg::REG_WEIGHT_Y: prdata = gpc_pkg::CFG_W'(weights_q.y);
			gpc_pkg::REG_WEIGHT_Z: prdata = gpc_pkg::CFG_W'(weights_q.z);
			default:               prdata = '0;
		endcase
	end

endmodule

FILE: rtl/core/gaussian_puff_concentration_sum.sv
// channel    dir  handshake      payload
// puff_in    in   valid/ready    query_x/y/z, puff_x/y/z, puff_present, first_puff, last_puff
// conc_out   out  valid/ready    concentration, saturated
// apb        in   psel/penable   weight_x @0x0, weight_y @0x4, weight_z @0x8
//
// A puff item passes from its acceptance to the next possible acceptance through
// the accepting cycle, the schedule steps (eight passes through the one shared
// 32x17 multiplier: three |d|^2, three weight products, log2(e) scaling, 1/norm
// scaling; plus a step to add the z term and an exp lookup) and the accumulate
// cycle. An item with puff_present low goes from acceptance straight to accumulate.
// Async reset clears the sum, saturation mark, sequencer and output valid.
// A last item stalls in its accumulate cycle while the previous result waits.
module gaussian_puff_concentration_sum (
	input  logic                             clk,
	input  logic                             arst_n,
	gpc_in_if.sink                           puff_in,
	gpc_out_if.source                        conc_out,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [gpc_pkg::REG_ADDR_W-1:0]   paddr,
	input  logic [gpc_pkg::CFG_W-1:0]        pwdata,
	output logic [gpc_pkg::CFG_W-1:0]        prdata,
	output logic                             pready
);

	// sequencer states, one-hot
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	// multiplier schedule inside ST_CALC
	localparam logic [3:0] STEP_SQ_X   = 4'd0;
	localparam logic [3:0] STEP_WT_X   = 4'd1;
	localparam logic [3:0] STEP_SQ_Y   = 4'd2;
	localparam logic [3:0] STEP_WT_Y   = 4'd3;
	localparam logic [3:0] STEP_SQ_Z   = 4'd4;
	localparam logic [3:0] STEP_WT_Z   = 4'd5;
	localparam logic [3:0] STEP_ACC_Z  = 4'd6;
	localparam logic [3:0] STEP_LOG2E  = 4'd7;
	localparam logic [3:0] STEP_EXP    = 4'd8;
	localparam logic [3:0] STEP_NORM   = 4'd9;

	localparam int unsigned MUL_A_W = 32;
	localparam int unsigned MUL_B_W = 17;
	localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
	localparam int unsigned ACC_W   = 50;    // three 48-bit terms
	localparam int unsigned IDX_W   = gpc_pkg::EXP_IDX_W;
	localparam int unsigned EXP_W   = gpc_pkg::EXP_W;

	gpc_pkg::weights_t weights;

	gpc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.weights (weights)
	);

	state_t             state_q;
	logic [3:0]         step_q;
	logic [15:0]        ax_q, ay_q, az_q;     // |query - puff| per axis
	logic               present_q, first_q, last_q;
	logic [PROD_W-1:0]  prod_q;
	logic [ACC_W-1:0]   acc_q;
	logic [EXP_W-1:0]   exp_q;
	logic [gpc_pkg::SUM_W-1:0] sum_q;
	logic               sat_mark_q;
	logic               out_valid_q;
	logic [gpc_pkg::SUM_W-1:0] conc_q;
	logic               out_sat_q;

	logic               in_acc;
	logic [16:0]        dx, dy, dz;
	logic [16:0]        adx, ady, adz;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  mul_p;
	logic [19:0]        power;
	logic               power_big;
	logic [4:0]         exp_shift;
	logic [IDX_W-1:0]   exp_idx;
	logic [EXP_W-1:0]   exp_val;
	logic [32:0]        round_sum;
	logic [15:0]        contrib;
	logic [gpc_pkg::SUM_W-1:0] sum_base;
	logic               mark_base;
	logic [gpc_pkg::SUM_W:0]   sum_ext;
	logic               sum_hit;
	logic [gpc_pkg::SUM_W-1:0] sum_next;
	logic               mark_next;
	logic               done_stall;

	assign puff_in.ready = (state_q == ST_IDLE);
	assign in_acc        = puff_in.valid & puff_in.ready;

	// differences are exact in 17 bits; magnitude fits 16
	assign dx  = {puff_in.query_x[15], puff_in.query_x} - {puff_in.puff_x[15], puff_in.puff_x};
	assign dy  = {puff_in.query_y[15], puff_in.query_y} - {puff_in.puff_y[15], puff_in.puff_y};
	assign dz  = {puff_in.query_z[15], puff_in.query_z} - {puff_in.puff_z[15], puff_in.puff_z};
	assign adx = dx[16] ? 17'(-dx) : dx;
	assign ady = dy[16] ? 17'(-dy) : dy;
	assign adz = dz[16] ? 17'(-dz) : dz;

	// shared multiplier operand select
	always_comb begin
		case (step_q)
			STEP_SQ_X:  begin mul_a = MUL_A_W'(ax_q);      mul_b = MUL_B_W'(ax_q); end
			STEP_WT_X:  begin mul_a = prod_q[MUL_A_W-1:0]; mul_b = MUL_B_W'(weights.x); end
			STEP_SQ_Y:  begin mul_a = MUL_A_W'(ay_q);      mul_b = MUL_B_W'(ay_q); end
			STEP_WT_Y:  begin mul_a = prod_q[MUL_A_W-1:0]; mul_b = MUL_B_W'(weights.y); end
			STEP_SQ_Z:  begin mul_a = MUL_A_W'(az_q);      mul_b = MUL_B_W'(az_q); end
			STEP_WT_Z:  begin mul_a = prod_q[MUL_A_W-1:0]; mul_b = MUL_B_W'(weights.z); end
			STEP_LOG2E: begin mul_a = MUL_A_W'(power);     mul_b = gpc_pkg::LOG2E_Q16; end
			STEP_NORM:  begin mul_a = MUL_A_W'(exp_q);
			                  mul_b = MUL_B_W'(gpc_pkg::INV_NORM_Q16); end
			default:    begin mul_a = '0;                  mul_b = '0; end
		endcase
	end

	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// power in Q4.16; at 16.0 or above the exp term is zero
	assign power     = acc_q[35:16];
	assign power_big = |acc_q[ACC_W-1:36];

	// prod_q holds power*log2(e) in Q17.32: integer part shifts, top fraction bits index
	assign exp_shift = prod_q[36:32];
	assign exp_idx   = prod_q[31 -: IDX_W];
	assign exp_val   = gpc_pkg::EXP2_TABLE[exp_idx] >> exp_shift;

	// round half up back to Q16
	assign round_sum = prod_q[32:0] + 33'd32768;
	assign contrib   = present_q ? round_sum[31:16] : 16'd0;

	assign sum_base  = first_q ? '0 : sum_q;
	assign mark_base = first_q ? 1'b0 : sat_mark_q;
	assign sum_ext   = {1'b0, sum_base} + (gpc_pkg::SUM_W + 1)'(contrib);
	assign sum_hit   = present_q & (sum_ext >= {1'b0, {gpc_pkg::SUM_W{1'b1}}});
	assign sum_next  = sum_hit ? {gpc_pkg::SUM_W{1'b1}} : sum_ext[gpc_pkg::SUM_W-1:0];
	assign mark_next = mark_base | sum_hit;

	assign done_stall = last_q & out_valid_q & ~conc_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_SQ_X;
			sum_q       <= '0;
			sat_mark_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result may replace the one taken in this same cycle
			if (state_q == ST_DONE && !done_stall && last_q) begin
				out_valid_q <= 1'b1;
			end else if (conc_out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						step_q  <= STEP_SQ_X;
						state_q <= puff_in.puff_present ? ST_CALC : ST_DONE;
					end
				end
				ST_CALC: begin
					step_q <= step_q + 4'd1;
					if (step_q == STEP_NORM) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!done_stall) begin
						sum_q      <= sum_next;
						sat_mark_q <= mark_next;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ax_q      <= adx[15:0];
			ay_q      <= ady[15:0];
			az_q      <= adz[15:0];
			present_q <= puff_in.puff_present;
			first_q   <= puff_in.first_puff;
			last_q    <= puff_in.last_puff;
		end
		if (state_q == ST_CALC) begin
			prod_q <= mul_p;
			case (step_q)
				STEP_SQ_Y:  acc_q <= ACC_W'(prod_q);
				STEP_SQ_Z:  acc_q <= acc_q + ACC_W'(prod_q);
				STEP_ACC_Z: acc_q <= acc_q + ACC_W'(prod_q);
				STEP_EXP:   exp_q <= power_big ? '0 : exp_val;
				default: ;
			endcase
		end
		if (state_q == ST_DONE && !done_stall && last_q) begin
			conc_q    <= sum_next;
			out_sat_q <= mark_next;
		end
	end

	assign conc_out.valid         = out_valid_q;
	assign conc_out.concentration = conc_q;
	assign conc_out.saturated     = out_sat_q;

`ifndef SYNTHESIS
	// mark is only ever set together with a clamped sum
	a_mark_means_max: assert property (@(posedge clk) disable iff (!arst_n)
		sat_mark_q |-> (sum_q == {gpc_pkg::SUM_W{1'b1}}))
		else $error("saturation mark set with sum below maximum");

	// an empty item skips the multiplier schedule
	a_empty_skips: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !puff_in.puff_present) |=> (state_q == ST_DONE))
		else $error("empty item entered the multiplier schedule");

	// schedule never runs past its last multiply
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC) |-> (step_q <= STEP_NORM))
		else $error("step counter out of range");

	// one puff adds at most 1/norm
	a_contrib_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (contrib <= gpc_pkg::INV_NORM_Q16))
		else $error("contribution above 1/norm");
`endif

endmodule
